FILE: rtl/eled_pkg.sv
// Shared types and constants for the echoing line editor.
// Used by the front, queue, back and top-level modules; no dependencies.
package eled_pkg;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BEL   = 8'h07;

    // line buffer size and register reset
    localparam logic [8:0] LINE_MAX   = 9'd256;
    localparam logic [8:0] MAX_LEN_RST = 9'd64;
    localparam logic [8:0] LEN_SAT    = 9'h1FF;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // command kinds produced by the front
    typedef enum logic [1:0] {
        K_STORE = 2'd0,
        K_LINE  = 2'd1,
        K_BS    = 2'd2,
        K_BEL   = 2'd3
    } t_kind;

    // one classified byte
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [8:0] idx;
        logic [8:0] len;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [7:0] echo_char;
        logic       last_of_run;
        logic       store_valid;
        logic [8:0] store_index;
        logic [7:0] store_char;
        logic       line_done;
        logic [8:0] line_length;
    } t_result;

endpackage

FILE: rtl/eled_front.sv
// Front end: holds max_length and the character count, classifies each byte.
// Depends on eled_pkg.
module eled_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [8:0]     i_cfg_data,
    input  logic           i_push_en,
    input  logic [7:0]     i_rx_char,
    output eled_pkg::t_cmd o_cmd
);
    import eled_pkg::*;

    logic [8:0] r_max_len;
    logic [8:0] r_count;
    logic [8:0] n_count;
    logic [8:0] limit;
    logic [9:0] len_sum;
    logic       is_end;
    logic       is_bs;
    logic       is_prn;

    // effective limit never exceeds the buffer
    assign limit = (r_max_len > LINE_MAX) ? LINE_MAX : r_max_len;

    // classification
    assign is_end  = (i_rx_char == CH_LF) || (i_rx_char == CH_CR);
    assign is_bs   = (i_rx_char == CH_BS) && (r_count != 9'd0);
    assign is_prn  = (i_rx_char >= CH_SP) && (i_rx_char <= CH_TILDE) && (r_count < limit);
    assign len_sum = {1'b0, r_count} + 10'd1;

    // command build and next count
    always_comb begin
        o_cmd   = '0;
        n_count = r_count;
        if (is_end) begin
            o_cmd.kind = K_LINE;
            o_cmd.idx  = r_count;
            if (r_count != 9'd0) begin
                o_cmd.len = len_sum[9] ? LEN_SAT : len_sum[8:0];
            end
            n_count = 9'd0;
        end else if (is_bs) begin
            o_cmd.kind = K_BS;
            n_count    = r_count - 9'd1;
        end else if (is_prn) begin
            o_cmd.kind = K_STORE;
            o_cmd.ch   = i_rx_char;
            o_cmd.idx  = r_count;
            n_count    = r_count + 9'd1;
        end else begin
            o_cmd.kind = K_BEL;
        end
    end

    // count and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 9'd0;
            r_max_len <= MAX_LEN_RST;
        end else begin
            if (i_push_en) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

endmodule

FILE: rtl/eled_fifo.sv
// Short command queue between front and back.
// Depends on eled_pkg.
module eled_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  eled_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output eled_pkg::t_cmd o_head,
    output logic           o_full,
    output logic           o_empty
);
    import eled_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_fill;

    assign o_full  = (r_fill == (QAW+1)'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/eled_back.sv
// Back end: expands queued commands into result items, one per cycle
// while the output is not stalled. Depends on eled_pkg.
module eled_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eled_pkg::t_cmd    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output eled_pkg::t_result o_res
);
    import eled_pkg::*;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       load;

    assign load = !i_empty && (!r_out_valid || !i_out_stall);

    // result for the head command at the current phase
    always_comb begin
        n_res = '0;
        case (i_head.kind)
            K_LINE: begin
                n_res.echo_char   = CH_LF;
                n_res.last_of_run = 1'b1;
                n_res.store_valid = 1'b1;
                n_res.store_index = i_head.idx;
                n_res.line_done   = 1'b1;
                n_res.line_length = i_head.len;
            end
            K_STORE: begin
                n_res.echo_char   = i_head.ch;
                n_res.last_of_run = 1'b1;
                n_res.store_valid = 1'b1;
                n_res.store_index = i_head.idx;
                n_res.store_char  = i_head.ch;
            end
            K_BS: begin
                n_res.echo_char   = (r_phase == 2'd1) ? CH_SP : CH_BS;
                n_res.last_of_run = (r_phase == 2'd2);
            end
            default: begin
                n_res.echo_char   = CH_BEL;
                n_res.last_of_run = 1'b1;
            end
        endcase
    end

    // backspace runs three results before the command leaves the queue
    assign o_pop = load && n_res.last_of_run;
    always_comb begin
        n_phase = r_phase;
        if (load && (i_head.kind == K_BS)) begin
            n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 2'd0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

`ifndef SYNTH
    a_phase_bs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 2'd0) |-> (!i_empty && i_head.kind == K_BS))
        else $error("backspace phase without backspace command");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.line_done || r_res.store_valid)) |-> r_res.last_of_run)
        else $error("store or line end not last of run");
    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.store_valid) |->
        (r_res.store_index == 9'd0 && r_res.store_char == 8'd0))
        else $error("store fields set without store");
`endif

endmodule

FILE: rtl/echoing_line_editor.sv
// Echoing line editor: one received byte in, one to three echo results out.
// A byte's command is registered in the command queue and its result in the output register.
// Bytes are taken one per cycle while the queue is not full; a backspace yields three results,
// as the single output register drains the four-entry command queue.
// Reset (synchronous, active low): count 0, max_length 64, queue and output empty.
module echoing_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_char,
    output logic       o_last_of_run,
    output logic       o_store_valid,
    output logic [8:0] o_store_index,
    output logic [7:0] o_store_char,
    output logic       o_line_done,
    output logic [8:0] o_line_length
);
    import eled_pkg::*;

    t_cmd    cmd;
    t_cmd    head;
    t_result res;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = full;
    assign push        = i_rx_valid && !full;

    // classify and count
    eled_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push_en   (push),
        .i_rx_char   (i_rx_char),
        .o_cmd       (cmd)
    );

    // command queue
    eled_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    // result generation
    eled_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_echo_char   = res.echo_char;
    assign o_last_of_run = res.last_of_run;
    assign o_store_valid = res.store_valid;
    assign o_store_index = res.store_index;
    assign o_store_char  = res.store_char;
    assign o_line_done   = res.line_done;
    assign o_line_length = res.line_length;

endmodule
